/* rtl/pdfsc_pkg.sv */
package pdfsc_pkg;

  // field widths
  localparam int CMD_W    = 2;
  localparam int WORD_W   = 16;
  localparam int SLOT_W   = 4;
  localparam int VOLTS_W  = 8;
  localparam int TARGET_W = 16;
  localparam int STATUS_W = 3;
  localparam int POS_W    = 4;
  localparam int CUR_W    = 13;
  localparam int MV_W     = 15;
  localparam int COUNT_W  = 4;

  // command codes
  localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REQUEST = 2'd1;
  localparam logic [CMD_W-1:0] CMD_BEST    = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK            = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UNSUPPORTED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_AVAILABLE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_IGNORED       = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL          = 3'd4;

  // offer word layout
  localparam int BIT_DETECTED = 15;
  localparam int BIT_TYPE     = 14;

  // voltage code step in mV
  localparam logic [MV_W-1:0] VOLT_STEP_MV = 15'd100;

  // canonical voltages
  localparam logic [MV_W-1:0] MV_5V  = 15'd5000;
  localparam logic [MV_W-1:0] MV_9V  = 15'd9000;
  localparam logic [MV_W-1:0] MV_15V = 15'd15000;
  localparam logic [MV_W-1:0] MV_20V = 15'd20000;

  // controller to datapath
  typedef struct packed {
    logic capture;   // latch input word
    logic prep;      // load decision / table write, reset scan
    logic step;      // examine one entry
    logic publish;   // move result into output register
  } pdfsc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
  } pdfsc_stat_t;

  // upper-bound current in mA for a 4-bit current code
  function automatic logic [CUR_W-1:0] current_upper_ma(input logic [3:0] code);
    logic [CUR_W-1:0] ma;
    unique case (code)
      4'd0:  ma = 13'd1240;
      4'd1:  ma = 13'd1490;
      4'd2:  ma = 13'd1740;
      4'd3:  ma = 13'd1990;
      4'd4:  ma = 13'd2240;
      4'd5:  ma = 13'd2490;
      4'd6:  ma = 13'd2740;
      4'd7:  ma = 13'd2990;
      4'd8:  ma = 13'd3240;
      4'd9:  ma = 13'd3490;
      4'd10: ma = 13'd3740;
      4'd11: ma = 13'd3990;
      4'd12: ma = 13'd4240;
      4'd13: ma = 13'd4490;
      4'd14: ma = 13'd4990;
      default: ma = 13'd5000;
    endcase
    return ma;
  endfunction

endpackage

/* rtl/pd_fixed_supply_capability_table.sv */
// channel | handshake             | word
// --------+-----------------------+-------------------------------------------------
// in      | in_valid / in_stall   | command, offer_word, slot_index, first_word,
//         |                       | request_volts, min_mv
// out     | out_valid / out_stall | status, offer_position, max_current_ma,
//         |                       | voltage_mv, entry_count, has_*_volt
//
// Each word passes through accept, prep/write, one step per held entry, scan end and
// publish; the scan reads the table one entry per step through its single read port.
// A new word is taken once the previous one has been placed in the output register.
// rst_n is synchronous, active low; it empties the table and drops any pending word.
// out_stall holds the output register; the block scans its current word and waits to publish.

module pd_fixed_supply_capability_table #(
  parameter int TABLE_DEPTH  = 8,
  parameter int SOURCE_SLOTS = 13
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [pdfsc_pkg::CMD_W-1:0]         in_command,
  input  logic [pdfsc_pkg::WORD_W-1:0]        in_offer_word,
  input  logic [pdfsc_pkg::SLOT_W-1:0]        in_slot_index,
  input  logic                                in_first_word,
  input  logic [pdfsc_pkg::VOLTS_W-1:0]       in_request_volts,
  input  logic [pdfsc_pkg::TARGET_W-1:0]      in_min_mv,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [pdfsc_pkg::STATUS_W-1:0]      out_status,
  output logic [pdfsc_pkg::POS_W-1:0]         out_offer_position,
  output logic [pdfsc_pkg::CUR_W-1:0]         out_max_current_ma,
  output logic [pdfsc_pkg::MV_W-1:0]          out_voltage_mv,
  output logic [pdfsc_pkg::COUNT_W-1:0]       out_entry_count,
  output logic                                out_has_five_volt,
  output logic                                out_has_nine_volt,
  output logic                                out_has_fifteen_volt,
  output logic                                out_has_twenty_volt
);

  pdfsc_pkg::pdfsc_cmd_t  cmd;
  pdfsc_pkg::pdfsc_stat_t stat;

  // sequencer
  pdfsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // offer table and result datapath
  pdfsc_dp #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .SOURCE_SLOTS (SOURCE_SLOTS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .stat                 (stat),
    .in_command           (in_command),
    .in_offer_word        (in_offer_word),
    .in_slot_index        (in_slot_index),
    .in_first_word        (in_first_word),
    .in_request_volts     (in_request_volts),
    .in_min_mv            (in_min_mv),
    .out_status           (out_status),
    .out_offer_position   (out_offer_position),
    .out_max_current_ma   (out_max_current_ma),
    .out_voltage_mv       (out_voltage_mv),
    .out_entry_count      (out_entry_count),
    .out_has_five_volt    (out_has_five_volt),
    .out_has_nine_volt    (out_has_nine_volt),
    .out_has_fifteen_volt (out_has_fifteen_volt),
    .out_has_twenty_volt  (out_has_twenty_volt)
  );

endmodule

/* rtl/pdfsc_ctrl.sv */
module pdfsc_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  output logic                     out_valid,
  input  logic                     out_stall,
  input  pdfsc_pkg::pdfsc_stat_t   stat,
  output pdfsc_pkg::pdfsc_cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_SCAN,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  // command decode
  always_comb begin
    cmd.capture = (state_r == S_IDLE) && in_valid;
    cmd.prep    = (state_r == S_PREP);
    cmd.step    = (state_r == S_SCAN) && !stat.scan_done;
    cmd.publish = (state_r == S_FIN) && out_free;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_PREP;
      S_PREP: state_nxt = S_SCAN;
      S_SCAN: if (stat.scan_done) state_nxt = S_FIN;
      S_FIN:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // output word valid: set on publish, cleared when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.publish) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* rtl/pdfsc_dp.sv */
module pdfsc_dp #(
  parameter int TABLE_DEPTH  = 8,
  parameter int SOURCE_SLOTS = 13
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pdfsc_pkg::pdfsc_cmd_t               cmd,
  output pdfsc_pkg::pdfsc_stat_t              stat,
  input  logic [pdfsc_pkg::CMD_W-1:0]         in_command,
  input  logic [pdfsc_pkg::WORD_W-1:0]        in_offer_word,
  input  logic [pdfsc_pkg::SLOT_W-1:0]        in_slot_index,
  input  logic                                in_first_word,
  input  logic [pdfsc_pkg::VOLTS_W-1:0]       in_request_volts,
  input  logic [pdfsc_pkg::TARGET_W-1:0]      in_min_mv,
  output logic [pdfsc_pkg::STATUS_W-1:0]      out_status,
  output logic [pdfsc_pkg::POS_W-1:0]         out_offer_position,
  output logic [pdfsc_pkg::CUR_W-1:0]         out_max_current_ma,
  output logic [pdfsc_pkg::MV_W-1:0]          out_voltage_mv,
  output logic [pdfsc_pkg::COUNT_W-1:0]       out_entry_count,
  output logic                                out_has_five_volt,
  output logic                                out_has_nine_volt,
  output logic                                out_has_fifteen_volt,
  output logic                                out_has_twenty_volt
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // captured input word
  logic [pdfsc_pkg::CMD_W-1:0]    cmd_r;
  logic [pdfsc_pkg::WORD_W-1:0]   word_r;
  logic [pdfsc_pkg::SLOT_W-1:0]   slot_r;
  logic                           first_r;
  logic [pdfsc_pkg::MV_W-1:0]     want_mv_r;
  logic                           want_ok_r;
  logic [pdfsc_pkg::TARGET_W-1:0] target_r;

  // table and scan state
  logic [pdfsc_pkg::MV_W-1:0]     mem_mv   [TABLE_DEPTH];
  logic [pdfsc_pkg::CUR_W-1:0]    mem_cur  [TABLE_DEPTH];
  logic [pdfsc_pkg::POS_W-1:0]    mem_pos  [TABLE_DEPTH];
  logic [CNT_W-1:0]               held_r;
  logic [CNT_W-1:0]               idx_r;

  // result being built
  logic                           hit_r;
  logic [pdfsc_pkg::STATUS_W-1:0] res_status_r;
  logic [pdfsc_pkg::POS_W-1:0]    res_pos_r;
  logic [pdfsc_pkg::CUR_W-1:0]    res_cur_r;
  logic [pdfsc_pkg::MV_W-1:0]     res_mv_r;
  logic [3:0]                     flags_r;

  // output register
  logic [pdfsc_pkg::STATUS_W-1:0] out_status_r;
  logic [pdfsc_pkg::POS_W-1:0]    out_pos_r;
  logic [pdfsc_pkg::CUR_W-1:0]    out_cur_r;
  logic [pdfsc_pkg::MV_W-1:0]     out_mv_r;
  logic [pdfsc_pkg::COUNT_W-1:0]  out_count_r;
  logic [3:0]                     out_flags_r;

  // requested volts to canonical mV
  logic [pdfsc_pkg::MV_W-1:0]     want_mv;
  logic                           want_ok;
  always_comb begin
    want_ok = 1'b1;
    unique case (in_request_volts)
      8'd5:    want_mv = pdfsc_pkg::MV_5V;
      8'd9:    want_mv = pdfsc_pkg::MV_9V;
      8'd15:   want_mv = pdfsc_pkg::MV_15V;
      8'd20:   want_mv = pdfsc_pkg::MV_20V;
      default: begin
        want_mv = '0;
        want_ok = 1'b0;
      end
    endcase
  end

  // load decision
  logic [CNT_W-1:0]               cnt_base;
  logic                           word_ok;
  logic                           tbl_full;
  logic                           do_write;
  logic [pdfsc_pkg::MV_W-1:0]     new_mv;
  logic [pdfsc_pkg::CUR_W-1:0]    new_cur;
  logic [pdfsc_pkg::POS_W-1:0]    new_pos;

  assign cnt_base = first_r ? '0 : held_r;
  assign word_ok  = word_r[pdfsc_pkg::BIT_DETECTED] && !word_r[pdfsc_pkg::BIT_TYPE] &&
                    ({1'b0, slot_r} < 5'(SOURCE_SLOTS));
  assign tbl_full = (cnt_base >= CNT_W'(TABLE_DEPTH));
  assign do_write = cmd.prep && (cmd_r == pdfsc_pkg::CMD_LOAD) && word_ok && !tbl_full;
  assign new_mv   = 15'(word_r[7:0]) * pdfsc_pkg::VOLT_STEP_MV;
  assign new_cur  = pdfsc_pkg::current_upper_ma(word_r[13:10]);
  assign new_pos  = slot_r + 4'd1;

  // entry under scan
  logic [pdfsc_pkg::MV_W-1:0]     rd_mv;
  logic [pdfsc_pkg::CUR_W-1:0]    rd_cur;
  logic [pdfsc_pkg::POS_W-1:0]    rd_pos;
  logic                           take;

  assign rd_mv  = mem_mv[idx_r[IDX_W-1:0]];
  assign rd_cur = mem_cur[idx_r[IDX_W-1:0]];
  assign rd_pos = mem_pos[idx_r[IDX_W-1:0]];

  always_comb begin
    take = 1'b0;
    if (cmd_r == pdfsc_pkg::CMD_REQUEST) begin
      take = want_ok_r && !hit_r && (rd_mv == want_mv_r);
    end else if (cmd_r == pdfsc_pkg::CMD_BEST) begin
      take = ({1'b0, rd_mv} >= target_r) && (!hit_r || (rd_cur > res_cur_r));
    end
  end

  assign stat.scan_done = (idx_r >= held_r);

  // final status
  logic [pdfsc_pkg::STATUS_W-1:0] fin_status;
  logic                           fin_fields;
  always_comb begin
    fin_status = res_status_r;
    if (res_status_r == pdfsc_pkg::ST_OK && !hit_r &&
        (cmd_r == pdfsc_pkg::CMD_REQUEST || cmd_r == pdfsc_pkg::CMD_BEST)) begin
      fin_status = pdfsc_pkg::ST_NOT_AVAILABLE;
    end
    fin_fields = (fin_status == pdfsc_pkg::ST_OK) && hit_r;
  end

  // table storage
  always_ff @(posedge clk) begin
    if (do_write) begin
      mem_mv[cnt_base[IDX_W-1:0]]  <= new_mv;
      mem_cur[cnt_base[IDX_W-1:0]] <= new_cur;
      mem_pos[cnt_base[IDX_W-1:0]] <= new_pos;
    end
  end

  // held count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (cmd.prep && cmd_r == pdfsc_pkg::CMD_LOAD) begin
      held_r <= do_write ? cnt_base + CNT_W'(1) : cnt_base;
    end
  end

  // capture, prep, scan, publish
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r     <= in_command;
      word_r    <= in_offer_word;
      slot_r    <= in_slot_index;
      first_r   <= in_first_word;
      want_mv_r <= want_mv;
      want_ok_r <= want_ok;
      target_r  <= in_min_mv;
    end

    if (cmd.prep) begin
      idx_r   <= '0;
      flags_r <= '0;
      hit_r   <= 1'b0;
      res_status_r <= pdfsc_pkg::ST_OK;
      if (cmd_r == pdfsc_pkg::CMD_LOAD) begin
        if (!word_ok) begin
          res_status_r <= pdfsc_pkg::ST_IGNORED;
        end else if (tbl_full) begin
          res_status_r <= pdfsc_pkg::ST_FULL;
        end else begin
          hit_r     <= 1'b1;
          res_pos_r <= new_pos;
          res_cur_r <= new_cur;
          res_mv_r  <= new_mv;
        end
      end else if (cmd_r == pdfsc_pkg::CMD_REQUEST && !want_ok_r) begin
        res_status_r <= pdfsc_pkg::ST_UNSUPPORTED;
      end
    end

    if (cmd.step) begin
      idx_r   <= idx_r + CNT_W'(1);
      flags_r <= flags_r | {rd_mv == pdfsc_pkg::MV_20V, rd_mv == pdfsc_pkg::MV_15V,
                            rd_mv == pdfsc_pkg::MV_9V,  rd_mv == pdfsc_pkg::MV_5V};
      if (take) begin
        hit_r     <= 1'b1;
        res_pos_r <= rd_pos;
        res_cur_r <= rd_cur;
        res_mv_r  <= rd_mv;
      end
    end

    if (cmd.publish) begin
      out_status_r <= fin_status;
      out_pos_r    <= fin_fields ? res_pos_r : '0;
      out_cur_r    <= fin_fields ? res_cur_r : '0;
      out_mv_r     <= fin_fields ? res_mv_r  : '0;
      out_count_r  <= 4'(held_r);
      out_flags_r  <= flags_r;
    end
  end

  assign out_status           = out_status_r;
  assign out_offer_position   = out_pos_r;
  assign out_max_current_ma   = out_cur_r;
  assign out_voltage_mv       = out_mv_r;
  assign out_entry_count      = out_count_r;
  assign out_has_five_volt    = out_flags_r[0];
  assign out_has_nine_volt    = out_flags_r[1];
  assign out_has_fifteen_volt = out_flags_r[2];
  assign out_has_twenty_volt  = out_flags_r[3];

endmodule
